// ----- hdl/ira_pkg.sv -----
// Shared constants, types, microcode program and helper functions for int_to_radix_ascii.
package ira_pkg;

	localparam int WORD_W         = 32;
	localparam int RADIX_W        = 6;
	localparam int SPACE_W        = 8;
	localparam int CHAR_W         = 8;
	localparam int LEN_W          = 6;
	localparam int WORD_DIGITS    = 32;
	localparam int DEF_MAX_DIGITS = 32;
	localparam int PC_W           = 4;

	// reciprocal of ten, scaled by 2^35
	localparam logic [WORD_W-1:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SH = 35;

	// base kinds
	localparam logic [1:0] K_BIN = 2'd0;
	localparam logic [1:0] K_OCT = 2'd1;
	localparam logic [1:0] K_DEC = 2'd2;
	localparam logic [1:0] K_HEX = 2'd3;

	// radix codes
	localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

	// characters
	localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_A    = 8'h61;

	// datapath actions
	localparam logic [3:0] ACT_NONE     = 4'd0;
	localparam logic [3:0] ACT_LOAD     = 4'd1;
	localparam logic [3:0] ACT_MUL      = 4'd2;
	localparam logic [3:0] ACT_DIG      = 4'd3;
	localparam logic [3:0] ACT_SETLEN   = 4'd4;
	localparam logic [3:0] ACT_EMIT_PRE = 4'd5;
	localparam logic [3:0] ACT_EMIT_DIG = 4'd6;
	localparam logic [3:0] ACT_EMIT_NUL = 4'd7;
	localparam logic [3:0] ACT_EMIT_ERR = 4'd8;

	// jump conditions
	localparam logic [3:0] C_NEVER    = 4'd0;
	localparam logic [3:0] C_ALWAYS   = 4'd1;
	localparam logic [3:0] C_NO_INPUT = 4'd2;
	localparam logic [3:0] C_BAD      = 4'd3;
	localparam logic [3:0] C_MORE     = 4'd4;
	localparam logic [3:0] C_OVF      = 4'd5;
	localparam logic [3:0] C_PRE_NONE = 4'd6;
	localparam logic [3:0] C_PRE_MORE = 4'd7;
	localparam logic [3:0] C_DIG_MORE = 4'd8;

	// program addresses
	localparam logic [PC_W-1:0] S_IDLE = 4'd0;
	localparam logic [PC_W-1:0] S_CHKB = 4'd1;
	localparam logic [PC_W-1:0] S_MUL  = 4'd2;
	localparam logic [PC_W-1:0] S_DIG  = 4'd3;
	localparam logic [PC_W-1:0] S_CHKS = 4'd4;
	localparam logic [PC_W-1:0] S_CHKP = 4'd5;
	localparam logic [PC_W-1:0] S_PRE  = 4'd6;
	localparam logic [PC_W-1:0] S_DIGO = 4'd7;
	localparam logic [PC_W-1:0] S_NUL  = 4'd8;
	localparam logic [PC_W-1:0] S_ERR  = 4'd9;

	typedef struct packed {
		logic [3:0]      act;
		logic [3:0]      cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic [3:0] act;
		logic       fire;
	} dp_ctrl_t;

	typedef struct packed {
		logic out_free;
		logic bad;
		logic more;
		logic ovf;
		logic pre_none;
		logic pre_more;
		logic dig_more;
	} dp_stat_t;

	// microcode ROM: next pc is target when the condition holds, else pc + 1
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			S_IDLE:  w = '{ACT_LOAD,     C_NO_INPUT, S_IDLE};
			S_CHKB:  w = '{ACT_NONE,     C_BAD,      S_ERR};
			S_MUL:   w = '{ACT_MUL,      C_NEVER,    S_IDLE};
			S_DIG:   w = '{ACT_DIG,      C_MORE,     S_MUL};
			S_CHKS:  w = '{ACT_SETLEN,   C_OVF,      S_ERR};
			S_CHKP:  w = '{ACT_NONE,     C_PRE_NONE, S_DIGO};
			S_PRE:   w = '{ACT_EMIT_PRE, C_PRE_MORE, S_PRE};
			S_DIGO:  w = '{ACT_EMIT_DIG, C_DIG_MORE, S_DIGO};
			S_NUL:   w = '{ACT_EMIT_NUL, C_ALWAYS,   S_IDLE};
			S_ERR:   w = '{ACT_EMIT_ERR, C_ALWAYS,   S_IDLE};
			default: w = '{ACT_NONE,     C_ALWAYS,   S_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + CHAR_W'(d);
		end else begin
			c = CH_A + CHAR_W'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

// ----- hdl/ira_seq.sv -----
// Microcode sequencer: step counter, program ROM lookup and jump logic.
module ira_seq
	import ira_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl,
	output logic     in_ready
);

	logic [PC_W-1:0] pc_q;
	uword_t          uw;
	logic            is_emit;
	logic            hold;
	logic            cond_hit;

	assign uw = ucode(pc_q);

	always_comb begin
		is_emit = (uw.act == ACT_EMIT_PRE) || (uw.act == ACT_EMIT_DIG) ||
			(uw.act == ACT_EMIT_NUL) || (uw.act == ACT_EMIT_ERR);
		hold = is_emit && !stat.out_free;
		case (uw.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_INPUT: cond_hit = !in_valid;
			C_BAD:      cond_hit = stat.bad;
			C_MORE:     cond_hit = stat.more;
			C_OVF:      cond_hit = stat.ovf;
			C_PRE_NONE: cond_hit = stat.pre_none;
			C_PRE_MORE: cond_hit = stat.pre_more;
			C_DIG_MORE: cond_hit = stat.dig_more;
			default:    cond_hit = 1'b1;
		endcase
	end

	assign ctrl.act  = uw.act;
	assign ctrl.fire = !hold && ((uw.act != ACT_LOAD) || in_valid);
	assign in_ready  = (pc_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (!hold) begin
			pc_q <= cond_hit ? uw.target : pc_q + 1'b1;
		end
	end

endmodule

// ----- hdl/ira_dp.sv -----
// Datapath: divide-by-base unit, digit buffer, length check and output register.
module ira_dp
	import ira_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_ctrl_t           ctrl,
	input  logic [WORD_W-1:0]  in_word,
	input  logic [RADIX_W-1:0] in_radix,
	input  logic [SPACE_W-1:0] in_space,
	input  logic               out_ready,
	output dp_stat_t           stat,
	output logic               out_valid,
	output logic [CHAR_W-1:0]  out_char,
	output logic               out_ok,
	output logic [LEN_W-1:0]   out_len,
	output logic               out_last
);

	localparam int CAP  = (MAX_DIGITS < WORD_DIGITS) ? MAX_DIGITS : WORD_DIGITS;
	localparam int NW   = $clog2(CAP + 1);
	localparam int IDXW = (CAP > 1) ? $clog2(CAP) : 1;

	logic [WORD_W-1:0]   v_q;
	logic [WORD_W-1:0]   q_q;
	logic [1:0]          kind_q;
	logic [SPACE_W-1:0]  space_q;
	logic                bad_q;
	logic [NW-1:0]       nd_q;
	logic                pi_q;
	logic [LEN_W-1:0]    len_q;
	logic [3:0]          dbuf_q [CAP];
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                ok_q;
	logic [LEN_W-1:0]    olen_q;
	logic                last_q;

	logic [2*WORD_W-1:0] prod;
	logic [WORD_W-1:0]   quot;
	logic [3:0]          rem;
	logic [3:0]          q_x10;
	logic [1:0]          pre_len;
	logic [LEN_W-1:0]    len_c;
	logic [SPACE_W-1:0]  total;
	logic [NW-1:0]       nd_m1;
	logic [1:0]          kind_in;
	logic                radix_ok;
	logic                emit_go;

	// quotient by base; ten goes through the reciprocal multiply
	always_comb begin
		prod = v_q * RECIP10;
		case (kind_q)
			K_BIN:   quot = {1'b0, v_q[WORD_W-1:1]};
			K_OCT:   quot = {3'b0, v_q[WORD_W-1:3]};
			K_HEX:   quot = {4'b0, v_q[WORD_W-1:4]};
			default: quot = WORD_W'(prod[2*WORD_W-1:RECIP10_SH]);
		endcase
	end

	// remainder; base ten takes it from the registered quotient; it stays below 16 so four bits do
	always_comb begin
		q_x10 = {q_q[0], 3'b0} + {q_q[2:0], 1'b0};
		case (kind_q)
			K_BIN:   rem = {3'b0, v_q[0]};
			K_OCT:   rem = {1'b0, v_q[2:0]};
			K_HEX:   rem = v_q[3:0];
			default: rem = v_q[3:0] - q_x10;
		endcase
	end

	always_comb begin
		case (kind_q)
			K_BIN, K_HEX: pre_len = 2'd2;
			K_OCT:        pre_len = 2'd1;
			default:      pre_len = 2'd0;
		endcase
		len_c = LEN_W'(nd_q) + LEN_W'(pre_len);
		total = SPACE_W'(len_c) + 8'd1;
		nd_m1 = nd_q - 1'b1;
	end

	always_comb begin
		case (in_radix)
			RADIX_BIN: begin kind_in = K_BIN; radix_ok = 1'b1; end
			RADIX_OCT: begin kind_in = K_OCT; radix_ok = 1'b1; end
			RADIX_DEC: begin kind_in = K_DEC; radix_ok = 1'b1; end
			RADIX_HEX: begin kind_in = K_HEX; radix_ok = 1'b1; end
			default:   begin kind_in = K_DEC; radix_ok = 1'b0; end
		endcase
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.bad      = bad_q;
	assign stat.more     = (q_q != '0) && ((NW + 1)'(nd_q) + 1'b1 < (NW + 1)'(CAP));
	assign stat.ovf      = total > space_q;
	assign stat.pre_none = (pre_len == 2'd0);
	assign stat.pre_more = !pi_q && (pre_len == 2'd2);
	assign stat.dig_more = nd_q > NW'(1);

	assign emit_go = ctrl.fire && ((ctrl.act == ACT_EMIT_PRE) || (ctrl.act == ACT_EMIT_DIG) ||
		(ctrl.act == ACT_EMIT_NUL) || (ctrl.act == ACT_EMIT_ERR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.act)
				ACT_LOAD: begin
					v_q     <= in_word;
					kind_q  <= kind_in;
					space_q <= in_space;
					bad_q   <= !radix_ok || (in_space == '0);
					nd_q    <= '0;
					pi_q    <= 1'b0;
				end
				ACT_MUL: begin
					q_q <= quot;
				end
				ACT_DIG: begin
					dbuf_q[nd_q[IDXW-1:0]] <= rem;
					nd_q <= nd_q + 1'b1;
					v_q  <= q_q;
				end
				ACT_SETLEN: begin
					len_q <= len_c;
				end
				ACT_EMIT_PRE: begin
					char_q <= !pi_q ? CH_ZERO : ((kind_q == K_BIN) ? CH_B : CH_X);
					ok_q   <= 1'b1;
					olen_q <= len_q;
					last_q <= 1'b0;
					pi_q   <= 1'b1;
				end
				ACT_EMIT_DIG: begin
					char_q <= digit_char(dbuf_q[nd_m1[IDXW-1:0]]);
					ok_q   <= 1'b1;
					olen_q <= len_q;
					last_q <= 1'b0;
					nd_q   <= nd_m1;
				end
				ACT_EMIT_NUL: begin
					char_q <= CH_NUL;
					ok_q   <= 1'b1;
					olen_q <= len_q;
					last_q <= 1'b1;
				end
				ACT_EMIT_ERR: begin
					char_q <= CH_NUL;
					ok_q   <= 1'b0;
					olen_q <= '0;
					last_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_ok    = ok_q;
	assign out_len   = olen_q;
	assign out_last  = last_q;

endmodule

// ----- hdl/int_to_radix_ascii.sv -----
// Top level of the unsigned integer to radix ASCII string converter.
// One input transaction carries a 32-bit value (read as unsigned), a radix and a buffer size.
// For radix 2, 8, 10 or 16 the block sends one output transaction per character: the prefix
// ("0b", "0", none, "0x"), the lower-case digits most significant first (zero gives one '0'),
// then a NUL with tlast set. Every character carries the string length without the NUL.
// An invalid radix, a zero size, or prefix + digits + NUL larger than the size gives a single
// transaction with char 0, ok 0, length 0 and tlast set. At most MAX_DIGITS low-order digits
// are kept. Timing: one item is worked on at a time. Each digit goes through the shared
// divide-by-base unit (a reciprocal multiply for base ten, a shift otherwise, then the
// remainder), each character goes through the single output register, and sequencer steps
// do the checks. A bad radix or a zero size is rejected at the check step after the load;
// a buffer that is too small is only found once the digits exist. A new input is taken
// once the last character of the previous run sits in the output register.
module int_to_radix_ascii
	import ira_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // word_value[31:0], radix[37:32], space_avail[45:38], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_char[7:0], str_length[13:8], zero pad
	output logic        m_tuser,   // ok_flag
	output logic        m_tlast    // last_flag
);

	dp_ctrl_t          ctrl;
	dp_stat_t          stat;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_len;

	ira_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.ctrl     (ctrl),
		.in_ready (s_tready)
	);

	ira_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_word   (s_tdata[31:0]),
		.in_radix  (s_tdata[37:32]),
		.in_space  (s_tdata[45:38]),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_char  (out_char),
		.out_ok    (m_tuser),
		.out_len   (out_len),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_len, out_char};

endmodule

// ----- hdl/ira_chk.sv -----
// Port-level checker for int_to_radix_ascii, bound to the top level.
module ira_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// an error result is the whole run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[13:0] == 14'd0))
		else $error("error result not single, or not zeroed");

	// a successful run ends in NUL with a non-zero length
	a_ok_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tlast |-> (m_tdata[7:0] == 8'd0) && (m_tdata[13:8] != 6'd0))
		else $error("bad run terminator");

	// non-final characters of a run are not NUL
	a_ok_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && !m_tlast |-> (m_tdata[7:0] != 8'd0))
		else $error("NUL before end of run");

	// one item at a time: no input taken right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

endmodule

bind int_to_radix_ascii ira_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
